[rtl/smf_pkg.sv]
`default_nettype none

package smf_pkg;

	// Fixed field widths
	localparam int CHUNK_W   = 32;
	localparam int LEVEL_W   = 8;
	localparam int STATUS_W  = 2;
	localparam int SLEVEL_W  = 3;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	// Operation codes carried on s_tuser
	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	// Result status codes carried on m_tuser
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Controller states
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the incoming transaction
		logic execute;  // run the queue operation, load the result register
	} cmd_t;

endpackage

`default_nettype wire

[rtl/smf_ctrl.sv]
`default_nettype none

module smf_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  wire             m_tready,
	output smf_pkg::cmd_t   cmd
);

	smf_pkg::state_t state_q;
	smf_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	// result register drains when the sink takes it
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			smf_pkg::S_IDLE: begin
				s_tready = out_free;
				if (s_tvalid && out_free) begin
					cmd.capture = 1'b1;
					state_d     = smf_pkg::S_EXEC;
				end
			end
			smf_pkg::S_EXEC: begin
				cmd.execute = 1'b1;
				state_d     = smf_pkg::S_IDLE;
			end
			default: begin
				state_d = smf_pkg::S_IDLE;
			end
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.execute) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[rtl/smf_dp.sv]
`default_nettype none

module smf_dp #(
	parameter int LEVELS = 8,
	parameter int DEPTH  = 256
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  smf_pkg::cmd_t                         cmd,
	input  wire                                   action,
	input  wire  [smf_pkg::CHUNK_W-1:0]           chunk_id,
	input  wire  [smf_pkg::LEVEL_W-1:0]           level,
	output logic [smf_pkg::STATUS_W-1:0]          status,
	output logic [smf_pkg::CHUNK_W-1:0]           served_chunk,
	output logic [smf_pkg::SLEVEL_W-1:0]          served_level
);

	localparam int LW = $clog2(LEVELS);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = LW + PW;
	localparam int MEM_ENTRIES = LEVELS * (2 ** PW);

	// captured transaction
	logic                        action_q;
	logic [smf_pkg::CHUNK_W-1:0] chunk_q;
	logic [LW-1:0]               lvl_q;
	logic [LW-1:0]               lvl_clamped;

	// per-level ring state
	logic [PW-1:0] rd_ptr_q [LEVELS];
	logic [PW-1:0] wr_ptr_q [LEVELS];
	logic [CW-1:0] cnt_q    [LEVELS];

	// entry storage, rows of 2**PW per level
	logic [smf_pkg::CHUNK_W-1:0] mem [MEM_ENTRIES];
	logic [smf_pkg::CHUNK_W-1:0] rd_data_q;

	// operation decode
	logic          found;
	logic [LW-1:0] sel;
	logic          full;
	logic          do_wr;
	logic          do_rd;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	// result register
	logic [smf_pkg::STATUS_W-1:0] status_q;
	logic [LW-1:0]                out_lvl_q;
	logic                         deq_ok_q;
	logic [7:0]                   out_lvl_wide;

	// clamp requested level to the lowest priority
	always_comb begin
		if (level >= 8'(LEVELS)) begin
			lvl_clamped = LW'(LEVELS - 1);
		end else begin
			lvl_clamped = level[LW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			chunk_q  <= chunk_id;
			lvl_q    <= lvl_clamped;
		end
	end

	// highest non-empty level, index 0 wins
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int p = LEVELS - 1; p >= 0; p--) begin
			if (cnt_q[p] != '0) begin
				found = 1'b1;
				sel   = LW'(p);
			end
		end
	end

	assign full    = (cnt_q[lvl_q] == CW'(DEPTH));
	assign do_wr   = cmd.execute && (action_q == smf_pkg::ACT_ENQ) && !full;
	assign do_rd   = cmd.execute && (action_q == smf_pkg::ACT_DEQ) && found;
	assign wr_addr = {lvl_q, wr_ptr_q[lvl_q]};
	assign rd_addr = {sel, rd_ptr_q[sel]};

	// pointer and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				cnt_q[i]    <= '0;
			end
		end else begin
			if (do_wr) begin
				if (wr_ptr_q[lvl_q] == PW'(DEPTH - 1)) begin
					wr_ptr_q[lvl_q] <= '0;
				end else begin
					wr_ptr_q[lvl_q] <= wr_ptr_q[lvl_q] + 1'b1;
				end
				cnt_q[lvl_q] <= cnt_q[lvl_q] + 1'b1;
			end
			if (do_rd) begin
				if (rd_ptr_q[sel] == PW'(DEPTH - 1)) begin
					rd_ptr_q[sel] <= '0;
				end else begin
					rd_ptr_q[sel] <= rd_ptr_q[sel] + 1'b1;
				end
				cnt_q[sel] <= cnt_q[sel] - 1'b1;
			end
		end
	end

	// storage write and registered read
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_addr] <= chunk_q;
		end
		if (do_rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			deq_ok_q  <= do_rd;
			out_lvl_q <= do_rd ? sel : '0;
			if (action_q == smf_pkg::ACT_ENQ) begin
				status_q <= full ? smf_pkg::ST_FULL : smf_pkg::ST_OK;
			end else begin
				status_q <= found ? smf_pkg::ST_OK : smf_pkg::ST_EMPTY;
			end
		end
	end

	assign out_lvl_wide = 8'(out_lvl_q);
	assign status       = status_q;
	assign served_chunk = deq_ok_q ? rd_data_q : '0;
	assign served_level = out_lvl_wide[smf_pkg::SLEVEL_W-1:0];

endmodule

`default_nettype wire

[rtl/strict_priority_multi_fifo.sv]
`default_nettype none

// Strict-priority multi-FIFO: LEVELS ring queues of 32-bit chunk indices,
// level 0 highest, each holding up to DEPTH entries. A transaction with
// s_tuser = 0 enqueues chunk_id at its level (levels past the last clamp to
// the last) and answers status 1 if that level is full. A transaction with
// s_tuser = 1 dequeues the oldest entry of the highest non-empty level and
// returns it with its level, or status 2 when every level is empty. Each
// transaction yields exactly one result on the master side. One transaction
// is in flight at a time: it is captured in the idle state, then the level
// scan, pointer update and the single-port access to the entry memory
// (LEVELS rows of DEPTH words, DEPTH rounded up to a power of two) run in
// the execute state. A new transaction is taken as soon as the previous
// result is being taken. Counts and pointers clear at reset; no memory
// sweep is needed.
module strict_priority_multi_fifo #(
	parameter int LEVELS = 8,
	parameter int DEPTH  = 256
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [smf_pkg::S_TDATA_W-1:0]        s_tdata,  // [31:0] chunk_id, [39:32] level
	input  wire                                  s_tuser,  // [0] action
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [smf_pkg::M_TDATA_W-1:0]        m_tdata,  // [31:0] served_chunk,
	                                                       // [34:32] served_level, [39:35] zero
	output logic [smf_pkg::STATUS_W-1:0]         m_tuser   // [1:0] status
);

	smf_pkg::cmd_t                  cmd;
	logic [smf_pkg::CHUNK_W-1:0]    served_chunk;
	logic [smf_pkg::SLEVEL_W-1:0]   served_level;

	smf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	smf_dp #(
		.LEVELS (LEVELS),
		.DEPTH  (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (s_tuser),
		.chunk_id     (s_tdata[31:0]),
		.level        (s_tdata[39:32]),
		.status       (m_tuser),
		.served_chunk (served_chunk),
		.served_level (served_level)
	);

	// pack result, zero fill to whole bytes
	assign m_tdata = {5'b0, served_level, served_chunk};

endmodule

`default_nettype wire

[test/tb_top.sv]
`default_nettype none

module tb_top;

	localparam int NUM_LEVELS = 8;
	localparam int RING_DEPTH = 256;

	// Field widths taken from the package
	localparam int CHUNK_W   = smf_pkg::CHUNK_W;
	localparam int LEVEL_W   = smf_pkg::LEVEL_W;
	localparam int STATUS_W  = smf_pkg::STATUS_W;
	localparam int SLEVEL_W  = smf_pkg::SLEVEL_W;
	localparam int S_TDATA_W = smf_pkg::S_TDATA_W;
	localparam int M_TDATA_W = smf_pkg::M_TDATA_W;

	// One queue answer: status plus the served chunk and its level
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CHUNK_W-1:0]  chunk;
		logic [SLEVEL_W-1:0] lvl;
	} queue_answer_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // [31:0] chunk_id, [39:32] level
	logic                 s_tuser;   // [0] action
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;   // [31:0] served_chunk, [34:32] served_level
	logic [STATUS_W-1:0]  m_tuser;   // [1:0] status

	strict_priority_multi_fifo #(
		.LEVELS(NUM_LEVELS),
		.DEPTH (RING_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// Shadow copy of the per-level rings
	logic [CHUNK_W-1:0] ring_mem [NUM_LEVELS][RING_DEPTH];
	int unsigned        rd_slot  [NUM_LEVELS];
	int unsigned        wr_slot  [NUM_LEVELS];
	int unsigned        held     [NUM_LEVELS];

	queue_answer_t answers_due[$];
	queue_answer_t oldest;

	int errors     = 0;
	int n_sent     = 0;
	int n_enq_ok   = 0;
	int n_full     = 0;
	int n_deq_ok   = 0;
	int n_empty    = 0;
	int n_wraps    = 0;
	int stall_left = 0;
	bit idle_en    = 1'b0;

	always #5 clk = ~clk;

	// Strict-priority queue behavior for one transaction
	function automatic queue_answer_t prio_queue_op(input logic act,
			input logic [CHUNK_W-1:0] chunk, input logic [LEVEL_W-1:0] req_lvl);
		queue_answer_t r;
		int            q;
		r = '0;
		if (act == smf_pkg::ACT_ENQ) begin
			q = (int'(req_lvl) >= NUM_LEVELS) ? NUM_LEVELS - 1 : int'(req_lvl);
			if (held[q] >= RING_DEPTH) begin
				r.status = smf_pkg::ST_FULL;
				n_full++;
			end else begin
				ring_mem[q][wr_slot[q]] = chunk;
				wr_slot[q] = (wr_slot[q] + 1) % RING_DEPTH;
				if (wr_slot[q] == 0)
					n_wraps++;
				held[q]++;
				r.status = smf_pkg::ST_OK;
				n_enq_ok++;
			end
		end else begin
			r.status = smf_pkg::ST_EMPTY;
			for (int p = 0; p < NUM_LEVELS; p++) begin
				if (held[p] != 0) begin
					r.chunk  = ring_mem[p][rd_slot[p]];
					r.lvl    = SLEVEL_W'(p);
					rd_slot[p] = (rd_slot[p] + 1) % RING_DEPTH;
					held[p]--;
					r.status = smf_pkg::ST_OK;
					break;
				end
			end
			if (r.status == smf_pkg::ST_OK)
				n_deq_ok++;
			else
				n_empty++;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		$display("MISMATCH %s: got %h, expected %h", what, got, want);
		errors++;
	endtask

	// Drive one transaction; returns at the edge where it is accepted
	task automatic send_op(input logic act, input logic [CHUNK_W-1:0] chunk,
			input logic [LEVEL_W-1:0] req_lvl);
		if (idle_en && $urandom_range(0, 99) < 20) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {req_lvl, chunk};
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		answers_due.push_back(prio_queue_op(act, chunk, req_lvl));
		n_sent++;
		@(posedge clk);
	endtask

	// Level code for a queue; the last queue is also reached by clamped codes
	function automatic logic [LEVEL_W-1:0] code_for(input int lv);
		if (lv == NUM_LEVELS - 1)
			return LEVEL_W'($urandom_range(NUM_LEVELS - 1, 255));
		return LEVEL_W'(lv);
	endfunction

	// Result side backpressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 99) < 20) begin
			stall_left = int'($urandom_range(0, 9));
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare every accepted result with the oldest outstanding answer
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (answers_due.size() == 0) begin
				report_mismatch("result with nothing outstanding", m_tdata, '0);
			end else begin
				oldest = answers_due.pop_front();
				if (m_tuser !== oldest.status)
					report_mismatch("status", 40'(m_tuser), 40'(oldest.status));
				if (m_tdata[CHUNK_W-1:0] !== oldest.chunk)
					report_mismatch("served_chunk", 40'(m_tdata[CHUNK_W-1:0]),
						40'(oldest.chunk));
				if (m_tdata[CHUNK_W +: SLEVEL_W] !== oldest.lvl)
					report_mismatch("served_level", 40'(m_tdata[CHUNK_W +: SLEVEL_W]),
						40'(oldest.lvl));
			end
		end
	end

	// Field extremes, clamping, priority order and empty dequeues
	task automatic test_directed();
		idle_en = 1'b1;
		send_op(smf_pkg::ACT_DEQ, 32'hFFFF_FFFF, 8'hFF);
		send_op(smf_pkg::ACT_ENQ, 32'h0000_0000, 8'd0);
		send_op(smf_pkg::ACT_ENQ, 32'hFFFF_FFFF, 8'd7);
		send_op(smf_pkg::ACT_ENQ, 32'hA5A5_A5A5, 8'd8);
		send_op(smf_pkg::ACT_ENQ, 32'h5A5A_5A5A, 8'd255);
		send_op(smf_pkg::ACT_ENQ, 32'h0000_0001, 8'd3);
		send_op(smf_pkg::ACT_ENQ, 32'h8000_0000, 8'd128);
		send_op(smf_pkg::ACT_ENQ, 32'h0000_0002, 8'd0);
		repeat (7)
			send_op(smf_pkg::ACT_DEQ, $urandom(), LEVEL_W'($urandom_range(0, 255)));
		send_op(smf_pkg::ACT_DEQ, 32'h0000_0000, 8'd0);
		send_op(smf_pkg::ACT_ENQ, 32'h7FFF_FFFE, 8'd127);
		send_op(smf_pkg::ACT_ENQ, 32'h1234_5678, 8'd1);
		send_op(smf_pkg::ACT_DEQ, 32'h0000_0000, 8'd0);
		send_op(smf_pkg::ACT_DEQ, 32'h0000_0000, 8'd0);
	endtask

	// Fill one level past full from a random ring offset, then drain it
	task automatic test_fill_and_wrap();
		int lv;
		int k;
		lv = int'($urandom_range(0, NUM_LEVELS - 1));
		k  = int'($urandom_range(20, 200));
		idle_en = 1'($urandom_range(0, 1));
		repeat (k)
			send_op(smf_pkg::ACT_ENQ, $urandom(), code_for(lv));
		repeat (k)
			send_op(smf_pkg::ACT_DEQ, $urandom(), LEVEL_W'($urandom_range(0, 255)));
		repeat (RING_DEPTH + 3)
			send_op(smf_pkg::ACT_ENQ, $urandom(), code_for(lv));
		repeat (RING_DEPTH + 1)
			send_op(smf_pkg::ACT_DEQ, $urandom(), LEVEL_W'($urandom_range(0, 255)));
	endtask

	// Mixed traffic in phases with a shifting enqueue rate and hot level
	task automatic test_random_mix(input int phases);
		int                 enq_pct;
		int                 hot;
		int                 pick;
		logic [LEVEL_W-1:0] lv;
		for (int ph = 0; ph < phases; ph++) begin
			enq_pct = int'($urandom_range(25, 85));
			hot     = int'($urandom_range(0, NUM_LEVELS - 1));
			idle_en = ($urandom_range(0, 3) != 0);
			repeat (75) begin
				pick = int'($urandom_range(0, 99));
				if (pick < 50)
					lv = code_for(hot);
				else if (pick < 85)
					lv = LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
				else
					lv = LEVEL_W'($urandom_range(0, 255));
				send_op(($urandom_range(0, 99) < enq_pct) ? smf_pkg::ACT_ENQ
					: smf_pkg::ACT_DEQ, $urandom(), lv);
			end
		end
	endtask

	// Back-to-back traffic with no idling on either side
	task automatic test_full_rate(input int count);
		idle_en = 1'b0;
		repeat (count)
			send_op($urandom_range(0, 1) ? smf_pkg::ACT_DEQ : smf_pkg::ACT_ENQ,
				$urandom(), LEVEL_W'($urandom_range(0, 255)));
	endtask

	initial begin
		clk      = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = smf_pkg::ACT_ENQ;
		for (int p = 0; p < NUM_LEVELS; p++) begin
			rd_slot[p] = 0;
			wr_slot[p] = 0;
			held[p]    = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_wrap();
		test_random_mix(11);
		test_full_rate(170);
		s_tvalid <= 1'b0;

		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d transactions: %0d stored, %0d refused full, %0d served, %0d empty",
			n_sent, n_enq_ok, n_full, n_deq_ok, n_empty);
		$display("Write pointer wraps: %0d, mismatches: %0d", n_wraps, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("Timeout with %0d results outstanding", answers_due.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
rtl/smf_pkg.sv
rtl/smf_ctrl.sv
rtl/smf_dp.sv
rtl/strict_priority_multi_fifo.sv
test/tb_top.sv
